>>> rtl/tsrm_pkg.sv
package tsrm_pkg;

    // payload widths fixed by the channel definitions
    localparam int SLOT_W  = 3;
    localparam int ENTRY_W = 32;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 3;

    typedef enum logic [2:0] {
        ACT_INIT         = 3'd0,
        ACT_CREATE       = 3'd1,
        ACT_TERMINATE    = 3'd2,
        ACT_SUSPEND      = 3'd3,
        ACT_RESUME       = 3'd4,
        ACT_SET_CURRENT  = 3'd5,
        ACT_EXIT_CURRENT = 3'd6,
        ACT_QUERY        = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_NOT_INIT    = 3'd1,
        STS_NO_FREE     = 3'd2,
        STS_NULL        = 3'd3,
        STS_IDLE_TARGET = 3'd4,
        STS_NO_TASKS    = 3'd5,
        STS_NOT_IN_RING = 3'd6,
        STS_NOT_BLOCKED = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_BLOCKED = 2'd2,
        SLOT_TERM    = 2'd3
    } t_slot_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic walk;
        logic unlink;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_req;
        logic found;
        logic absent;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/tsrm_req_if.sv
interface tsrm_req_if;
    import tsrm_pkg::*;

    logic                valid;
    logic                ready;
    t_action             action;
    logic [SLOT_W-1:0]   slot;
    logic [ENTRY_W-1:0]  task_entry;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, action, slot, task_entry, priority_req, input ready);
    modport sink   (input valid, action, slot, task_entry, priority_req, output ready);

endinterface

>>> rtl/tsrm_rsp_if.sv
interface tsrm_rsp_if;
    import tsrm_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [SLOT_W-1:0]   result_slot;
    logic [SLOT_W-1:0]   current_slot;
    logic [ENTRY_W-1:0]  current_entry;
    logic [PRIO_W-1:0]   current_priority;
    logic [COUNT_W-1:0]  live_tasks;
    logic                initialized;

    modport source (output valid, status, result_slot, current_slot, current_entry,
                    current_priority, live_tasks, initialized, input ready);
    modport sink   (input valid, status, result_slot, current_slot, current_entry,
                    current_priority, live_tasks, initialized, output ready);

endinterface

>>> rtl/tsrm_ctrl.sv
module tsrm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tsrm_pkg::t_sts i_sts,
    output tsrm_pkg::t_cmd o_cmd
);
    import tsrm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_WALK   = 5'b00100,
        S_UNLINK = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // sequencing of one action
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no transfer while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.walk_req ? S_WALK : S_OUT;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                priority if (i_sts.found) begin
                    n_state = S_UNLINK;
                end else if (i_sts.absent) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/tsrm_dp.sv
module tsrm_dp #(
    parameter int NUM_SLOTS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tsrm_pkg::t_cmd                 i_cmd,
    output tsrm_pkg::t_sts                 o_sts,
    input  logic                           i_cfg_we,
    input  logic [tsrm_pkg::ENTRY_W-1:0]   i_cfg_wdata,
    input  tsrm_pkg::t_action              i_action,
    input  logic [tsrm_pkg::SLOT_W-1:0]    i_slot,
    input  logic [tsrm_pkg::ENTRY_W-1:0]   i_task_entry,
    input  logic [tsrm_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output tsrm_pkg::t_status              o_status,
    output logic [tsrm_pkg::SLOT_W-1:0]    o_result_slot,
    output logic [tsrm_pkg::SLOT_W-1:0]    o_current_slot,
    output logic [tsrm_pkg::ENTRY_W-1:0]   o_current_entry,
    output logic [tsrm_pkg::PRIO_W-1:0]    o_current_priority,
    output logic [tsrm_pkg::COUNT_W-1:0]   o_live_tasks,
    output logic                           o_initialized
);
    import tsrm_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int FD = NUM_SLOTS - 1;
    localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);
    localparam logic [SW-1:0] FULL = SW'(FD);

    // configuration and latched request
    logic [ENTRY_W-1:0] r_idle_entry;
    t_action            r_act;
    logic [SLOT_W-1:0]  r_slot;
    logic [ENTRY_W-1:0] r_task_entry;
    logic [PRIO_W-1:0]  r_prio_req;

    // scheduler state
    logic               r_init;
    logic [SW-1:0]      r_total;
    logic [SW-1:0]      r_cur;
    logic [SW-1:0]      r_tail;
    logic [SW-1:0]      r_depth;
    logic [SW-1:0]      r_free  [FD];
    logic [SW-1:0]      r_link  [NUM_SLOTS];
    t_slot_state        r_stat  [NUM_SLOTS];
    logic [PRIO_W-1:0]  r_prio  [NUM_SLOTS];
    logic [ENTRY_W-1:0] r_entry [NUM_SLOTS];

    // per-action working registers
    t_status            r_status;
    logic [SLOT_W-1:0]  r_rslot;
    logic [SW-1:0]      r_w;
    logic [SW-1:0]      r_n;
    logic [SW-1:0]      r_pred;

    // result register
    logic               r_out_valid;
    t_status            r_o_status;
    logic [SLOT_W-1:0]  r_o_rslot;
    logic [SLOT_W-1:0]  r_o_cur;
    logic [ENTRY_W-1:0] r_o_entry;
    logic [PRIO_W-1:0]  r_o_prio;
    logic [COUNT_W-1:0] r_o_live;
    logic               r_o_init;

    logic               is_exit;
    logic               kill;
    logic               slot_null;
    logic               t_null;
    logic [SW-1:0]      tgt;
    logic [SW-1:0]      link_raddr;
    logic [SW-1:0]      link_rd;
    t_slot_state        stat_t;
    logic [SW-1:0]      free_top;
    logic [SW-1:0]      app_slot;
    logic               hit;
    logic               absent;
    t_status            ex_status;
    logic               walk_ok;
    logic               do_init;
    logic               do_create;
    logic               do_resume;
    logic               do_setcur;

    // target slot and single read ports
    assign is_exit    = (r_act == ACT_EXIT_CURRENT);
    assign kill       = (r_act == ACT_TERMINATE) || is_exit;
    assign slot_null  = (int'(r_slot) >= NUM_SLOTS);
    assign t_null     = !is_exit && slot_null;
    assign tgt        = is_exit ? r_cur : SW'(r_slot);
    assign link_raddr = i_cmd.walk ? r_w : tgt;
    assign link_rd    = r_link[link_raddr];
    assign stat_t     = r_stat[tgt];
    assign free_top   = r_free[r_depth - 1'b1];
    assign app_slot   = do_create ? free_top : tgt;

    // ring walk step: predecessor found, or wrapped / out of links
    assign hit    = (link_rd == tgt);
    assign absent = !hit && (((r_w == r_cur) && (r_n != '0)) || (r_n == LAST));

    // error checks in reporting order
    always_comb begin
        ex_status = STS_OK;
        walk_ok   = 1'b0;
        do_init   = 1'b0;
        do_create = 1'b0;
        do_resume = 1'b0;
        do_setcur = 1'b0;
        unique case (r_act)
            ACT_INIT: begin
                do_init = 1'b1;
            end
            ACT_CREATE: begin
                priority if (!r_init) begin
                    ex_status = STS_NOT_INIT;
                end else if (r_task_entry == '0) begin
                    ex_status = STS_NULL;
                end else if (r_depth == '0) begin
                    ex_status = STS_NO_FREE;
                end else begin
                    do_create = 1'b1;
                end
            end
            ACT_TERMINATE, ACT_SUSPEND, ACT_EXIT_CURRENT: begin
                priority if (!r_init) begin
                    ex_status = STS_NOT_INIT;
                end else if (t_null) begin
                    ex_status = STS_NULL;
                end else if (tgt == '0) begin
                    ex_status = STS_IDLE_TARGET;
                end else if (r_total == '0) begin
                    ex_status = STS_NO_TASKS;
                end else begin
                    walk_ok = 1'b1;
                end
            end
            ACT_RESUME: begin
                priority if (!r_init) begin
                    ex_status = STS_NOT_INIT;
                end else if (t_null) begin
                    ex_status = STS_NULL;
                end else if (tgt == '0) begin
                    ex_status = STS_IDLE_TARGET;
                end else if (stat_t != SLOT_BLOCKED) begin
                    ex_status = STS_NOT_BLOCKED;
                end else if (r_total == '0) begin
                    ex_status = STS_NO_TASKS;
                end else begin
                    do_resume = 1'b1;
                end
            end
            ACT_SET_CURRENT: begin
                if (slot_null) begin
                    ex_status = STS_NULL;
                end else begin
                    do_setcur = 1'b1;
                end
            end
            ACT_QUERY: begin
                ex_status = STS_OK;
            end
        endcase
    end

    assign o_sts.walk_req = walk_ok;
    assign o_sts.found    = hit;
    assign o_sts.absent   = absent;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // scheduler state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_entry <= '0;
            r_init       <= 1'b0;
            r_total      <= '0;
            r_cur        <= '0;
            r_tail       <= '0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_link[i]  <= '0;
                r_stat[i]  <= SLOT_UNUSED;
                r_prio[i]  <= '0;
                r_entry[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_idle_entry <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                if (do_init) begin
                    r_init     <= 1'b1;
                    r_total    <= '0;
                    r_cur      <= '0;
                    r_tail     <= '0;
                    r_depth    <= FULL;
                    r_link[0]  <= '0;
                    r_prio[0]  <= '0;
                    r_entry[0] <= r_idle_entry;
                    r_stat[0]  <= SLOT_READY;
                end
                if (do_create) begin
                    r_depth           <= r_depth - 1'b1;
                    r_total           <= r_total + 1'b1;
                    r_prio[free_top]  <= r_prio_req;
                    r_entry[free_top] <= r_task_entry;
                end
                // append at the tail; a self-link resolves to zero
                if (do_create || do_resume) begin
                    r_link[r_tail]   <= app_slot;
                    r_link[app_slot] <= '0;
                    r_tail           <= app_slot;
                    r_stat[app_slot] <= SLOT_READY;
                end
                if (do_setcur) begin
                    r_cur <= tgt;
                end
            end
            if (i_cmd.unlink) begin
                r_link[r_pred] <= link_rd;
                if (tgt == r_tail) begin
                    r_tail <= r_pred;
                end
                if (tgt == r_cur) begin
                    r_cur <= link_rd;
                end
                if (kill) begin
                    r_stat[tgt] <= SLOT_TERM;
                    r_total     <= r_total - 1'b1;
                    if (r_depth != FULL) begin
                        r_depth <= r_depth + 1'b1;
                    end
                end else begin
                    r_stat[tgt] <= SLOT_BLOCKED;
                end
            end
            r_out_valid <= i_cmd.load_out || (r_out_valid && !i_out_ready);
        end
    end

    // request latch, walk registers, free stack and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act        <= i_action;
            r_slot       <= i_slot;
            r_task_entry <= i_task_entry;
            r_prio_req   <= i_priority_req;
            if (i_action == ACT_CREATE) begin
                r_rslot <= '0;
            end else if (i_action == ACT_EXIT_CURRENT) begin
                r_rslot <= SLOT_W'(r_cur);
            end else begin
                r_rslot <= i_slot;
            end
        end
        if (i_cmd.exec) begin
            r_status <= ex_status;
            r_w      <= r_cur;
            r_n      <= '0;
            if (do_create) begin
                r_rslot <= SLOT_W'(free_top);
            end
            // refill with slot one on top
            if (do_init) begin
                for (int k = 0; k < FD; k++) begin
                    r_free[k] <= SW'(FD - k);
                end
            end
        end
        if (i_cmd.walk) begin
            priority if (hit) begin
                r_pred <= r_w;
            end else if (absent) begin
                r_status <= STS_NOT_IN_RING;
            end else begin
                r_w <= link_rd;
                r_n <= r_n + 1'b1;
            end
        end
        if (i_cmd.unlink && kill && (r_depth != FULL)) begin
            r_free[r_depth] <= tgt;
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_rslot  <= r_rslot;
            r_o_cur    <= SLOT_W'(r_cur);
            r_o_entry  <= r_entry[r_cur];
            r_o_prio   <= r_prio[r_cur];
            r_o_live   <= COUNT_W'(r_total);
            r_o_init   <= r_init;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_result_slot      = r_o_rslot;
    assign o_current_slot     = r_o_cur;
    assign o_current_entry    = r_o_entry;
    assign o_current_priority = r_o_prio;
    assign o_live_tasks       = r_o_live;
    assign o_initialized      = r_o_init;

    // free slots plus live tasks never exceed the user slots
    a_stack_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((SW+1)'(r_depth) + (SW+1)'(r_total)) <= (SW+1)'(FD))
        else $error("free stack and task count out of balance");

    // current and tail always point at a real slot
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cur) < NUM_SLOTS) && (int'(r_tail) < NUM_SLOTS))
        else $error("current or tail outside slot pool");

    // a terminate or exit current drops the task count by exactly one
    a_kill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.unlink && kill) |=> (r_total == $past(r_total) - 1'b1))
        else $error("task count not decremented on terminate");

endmodule

>>> rtl/task_slot_ring_manager.sv
// Task slot ring manager: a pool of NUM_SLOTS slots, slot 0 the idle task.
// Request channel i_req carries one action (init, create, terminate,
// suspend, resume, set current, exit current, query) with a slot, an entry
// address and a priority; a transfer happens when valid and ready are high.
// Response channel o_rsp returns one result per request: status code, the
// result slot and a view of the current task, live count and init flag.
// i_cfg_we / i_cfg_wdata load the idle task's entry address, used by init.
// Sequence: after the request transfer the action is checked and executed,
// then the result is loaded into the output register; a terminate, suspend
// or exit current that passes its checks first walks the ready ring one
// link per cycle from the current task and, when the target is found,
// unlinks it before the result is loaded.
// One request is in work at a time; ready returns once the result is
// loaded into the output register.
// A stalled response holds in the output register while the next request is
// taken and worked up to its own result, which then waits for the slot.
// Reset clears all slot tables, pointers and counts; the block is usable at
// once and reports not initialized until an init action has run.
module task_slot_ring_manager #(
    parameter int NUM_SLOTS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tsrm_req_if.sink                      i_req,
    tsrm_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [tsrm_pkg::ENTRY_W-1:0]  i_cfg_wdata
);
    import tsrm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // action sequencer
    tsrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // slot tables, ring pointers and result register
    tsrm_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_action           (i_req.action),
        .i_slot             (i_req.slot),
        .i_task_entry       (i_req.task_entry),
        .i_priority_req     (i_req.priority_req),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_status           (o_rsp.status),
        .o_result_slot      (o_rsp.result_slot),
        .o_current_slot     (o_rsp.current_slot),
        .o_current_entry    (o_rsp.current_entry),
        .o_current_priority (o_rsp.current_priority),
        .o_live_tasks       (o_rsp.live_tasks),
        .o_initialized      (o_rsp.initialized)
    );

endmodule
